/* sv/bra_pkg.sv */
package bra_pkg;

  localparam int unsigned MaxBitsDefault  = 4096;
  localparam int unsigned WordBitsDefault = 32;

  localparam int unsigned OpW    = 4;
  localparam int unsigned StartW = 12;
  localparam int unsigned LenW   = 13;
  localparam int unsigned SizeW  = 13;

  localparam logic [OpW-1:0] OpAlloc      = 4'd0;
  localparam logic [OpW-1:0] OpSet        = 4'd1;
  localparam logic [OpW-1:0] OpClear      = 4'd2;
  localparam logic [OpW-1:0] OpFindSet    = 4'd3;
  localparam logic [OpW-1:0] OpFindSetRun = 4'd4;
  localparam logic [OpW-1:0] OpTest       = 4'd5;
  localparam logic [OpW-1:0] OpCountSet   = 4'd6;
  localparam logic [OpW-1:0] OpCountFree  = 4'd7;
  localparam logic [OpW-1:0] OpClearAll   = 4'd8;
  localparam logic [OpW-1:0] OpFreeRun    = 4'd9;
  localparam logic [OpW-1:0] OpSetRun     = 4'd10;

  typedef struct packed {
    logic [OpW-1:0]    op;
    logic [StartW-1:0] start_bit;
    logic [LenW-1:0]   run_length;
  } bra_req_t;

  typedef struct packed {
    logic              found;
    logic [StartW-1:0] position;
    logic [LenW-1:0]   run_count;
    logic              bit_value;
    logic              error;
  } bra_rsp_t;

endpackage

/* sv/bra_engine.sv */
module bra_engine import bra_pkg::*; #(
  parameter int unsigned MaxBits = MaxBitsDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  bra_req_t         req_i,
  input  logic [SizeW-1:0] size_i,
  output logic             idle_o,
  output logic             done_o,
  output bra_rsp_t         rsp_o
);

  localparam int unsigned IdxW = $clog2(MaxBits);

  typedef enum logic [7:0] {
    StIdle  = 8'b00000001,
    StRead  = 8'b00000010,
    StWait  = 8'b00000100,
    StScan  = 8'b00001000,
    StWrite = 8'b00010000,
    StClr   = 8'b00100000,
    StDone  = 8'b01000000,
    StInit  = 8'b10000000
  } state_e;

  // one bit per memory entry keeps the walk simple: the shared unit steps
  // one bit at a time through a bit-wide memory
  logic mem_q [MaxBits];
  logic rd_q;

  state_e          state_q, state_d;
  bra_req_t        req_q;
  logic [SizeW-1:0] lim_q;
  logic [SizeW:0]  idx_q, idx_d;      // current bit
  logic [SizeW:0]  end_q, end_d;      // write end (exclusive)
  logic [SizeW:0]  run_q, run_d;      // counter
  logic [SizeW:0]  pos_q, pos_d;
  logic            found_q, found_d, wval_q, wval_d, err_q, err_d, bv_q, bv_d;
  logic            phase_q, phase_d;  // find set run: measuring
  logic            we;
  logic [SizeW-1:0] lim_n;
  logic [SizeW:0]  rng;

  assign lim_n = (size_i > SizeW'(MaxBits)) ? SizeW'(MaxBits) : size_i;
  assign rng   = {1'b0, SizeW'(req_i.start_bit)} + {1'b0, req_i.run_length};

  always_ff @(posedge clk_i) begin
    if (we) mem_q[idx_q[IdxW-1:0]] <= (state_q == StWrite) ? wval_q : 1'b0;
    rd_q <= mem_q[idx_q[IdxW-1:0]];
  end

  always_comb begin
    state_d = state_q; idx_d = idx_q; end_d = end_q; run_d = run_q;
    pos_d = pos_q; found_d = found_q; wval_d = wval_q; err_d = err_q;
    bv_d = bv_q; phase_d = phase_q; we = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (start_i) begin
          idx_d = {1'b0, SizeW'(req_i.start_bit)};
          run_d = '0; pos_d = '0; found_d = 1'b0; err_d = 1'b0; bv_d = 1'b0;
          phase_d = 1'b0; end_d = rng; wval_d = (req_i.op == OpSet);
          if (req_i.op == OpClearAll) begin
            idx_d = '0; state_d = StClr;
          end else if (req_i.op > OpSetRun) begin
            state_d = StDone;
          end else if (SizeW'(req_i.start_bit) >= lim_n) begin
            err_d = 1'b1; state_d = StDone;
          end else if (req_i.op == OpSet || req_i.op == OpClear) begin
            if (rng > {1'b0, lim_n}) err_d = 1'b1;
            state_d = (rng > {1'b0, lim_n} || req_i.run_length == '0) ? StDone : StWrite;
          end else if (req_i.op == OpAlloc && req_i.run_length == '0) begin
            state_d = StDone;
          end else begin
            state_d = StRead;
          end
        end
      end
      // clear every entry; after reset drop straight back to idle
      StClr, StInit: begin
        we = 1'b1; idx_d = idx_q + 1'b1;
        if (idx_q == (SizeW+1)'(MaxBits - 1))
          state_d = (state_q == StClr) ? StDone : StIdle;
      end
      StWrite: begin
        we = 1'b1; idx_d = idx_q + 1'b1;
        if (idx_d == end_q) state_d = StDone;
      end
      StRead: state_d = StWait;
      StWait: state_d = StScan;
      StScan: begin
        state_d = StRead; idx_d = idx_q + 1'b1;
        unique case (req_q.op)
          OpAlloc: begin
            if (rd_q) run_d = '0;
            else begin
              run_d = run_q + 1'b1;
              if (run_d == {1'b0, req_q.run_length}) begin
                pos_d = idx_q + 1'b1 - {1'b0, req_q.run_length};
                found_d = 1'b1; wval_d = 1'b1; end_d = idx_q + 1'b1;
                idx_d = pos_d; state_d = StWrite;
              end
            end
          end
          OpFindSet, OpFindSetRun: begin
            if (rd_q) begin
              if (!phase_q) begin
                found_d = 1'b1; pos_d = idx_q; phase_d = 1'b1;
                if (req_q.op == OpFindSet) state_d = StDone;
              end
              run_d = run_q + 1'b1;
            end else if (phase_q) state_d = StDone;
          end
          OpTest: begin
            bv_d = rd_q; state_d = StDone;
          end
          OpCountSet:  if (rd_q)  run_d = run_q + 1'b1;
          OpCountFree: if (!rd_q) run_d = run_q + 1'b1;
          OpFreeRun: if (rd_q) state_d = StDone; else run_d = run_q + 1'b1;
          OpSetRun:  if (!rd_q) state_d = StDone; else run_d = run_q + 1'b1;
          default: state_d = StDone;
        endcase
        if (state_d == StRead && idx_d >= {1'b0, lim_q}) state_d = StDone;
      end
      StDone: state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StInit;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && start_i) begin
      req_q <= req_i; lim_q <= lim_n;
    end
    end_q <= end_d; run_q <= run_d; pos_q <= pos_d;
    found_q <= found_d; wval_q <= wval_d; err_q <= err_d; bv_q <= bv_d;
    phase_q <= phase_d;
  end

  assign idle_o = (state_q == StIdle);
  assign done_o = (state_q == StDone);
  always_comb begin
    rsp_o = '0;
    rsp_o.found     = found_q;
    rsp_o.position  = pos_q[StartW-1:0];
    rsp_o.bit_value = bv_q;
    rsp_o.error     = err_q;
    if (req_q.op != OpAlloc && req_q.op != OpFindSet && req_q.op != OpTest)
      rsp_o.run_count = run_q[LenW-1:0];
    if (err_q || req_q.op == OpClearAll) rsp_o = '0;
    if (err_q) rsp_o.error = 1'b1;
  end

endmodule

/* sv/bitmap_run_allocator.sv */
// First-fit run allocator over a bitmap of MaxBits bits. After reset the
// engine clears the bitmap store, one entry a cycle, and holds tready low
// until that pass is over, so every bit starts free.
// One request (op, start bit, run length) gives exactly one response.
// The engine walks the bitmap store one bit per memory read, through its
// read, wait and scan states; set and clear write one bit at a time, and
// clear all writes every entry; tready stays low meanwhile.
// The response waits in an output register, and the next request is taken
// once the engine is idle and that register is free. Write bitmap_size only
// while idle.
module bitmap_run_allocator import bra_pkg::*; #(
  parameter int unsigned MaxBits = MaxBitsDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [31:0]      s_axis_tdata,  // op[3:0], start_bit[15:4], run_length[28:16]
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [31:0]      m_axis_tdata,  // found, position, run_count, bit_value, error
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [SizeW-1:0] cfg_data_i
);

  logic [SizeW-1:0] size_q;
  logic             idle, ovalid_q, done;
  bra_req_t         req;
  bra_rsp_t         rsp, rsp_q;

  assign req.op         = s_axis_tdata[3:0];
  assign req.start_bit  = s_axis_tdata[15:4];
  assign req.run_length = s_axis_tdata[28:16];

  assign s_axis_tready = idle && !ovalid_q;
  assign cfg_ready_o   = 1'b1;

  bra_engine #(.MaxBits(MaxBits)) u_engine (
    .clk_i, .rst_ni,
    .start_i (s_axis_tvalid && s_axis_tready),
    .req_i   (req),
    .size_i  (size_q),
    .idle_o  (idle),
    .done_o  (done),
    .rsp_o   (rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= SizeW'(MaxBitsDefault); ovalid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) size_q <= cfg_data_i;
      // hold the response until taken
      if (done) ovalid_q <= 1'b1;
      else if (m_axis_tready) ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done) rsp_q <= rsp;
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = {4'd0, rsp_q.error, rsp_q.bit_value, rsp_q.run_count,
                          rsp_q.position, rsp_q.found};

endmodule

/* sv/bra_checker.sv */
module bra_checker (
  input logic clk_i, rst_ni, s_axis_tvalid, s_axis_tready, m_axis_tvalid, m_axis_tready
);
  a_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready) else $error("ready after accept");
  a_nout: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready) else $error("accept while output pending");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid) else $error("output dropped");
endmodule

bind bitmap_run_allocator bra_checker u_chk (.*);

/* tb/bitmap_run_allocator_tb.sv */
`timescale 1ns / 1ps

module bitmap_run_allocator_tb;
  import bra_pkg::*;

  localparam logic [OpW-1:0] OpSpareLo = 4'd11;
  localparam logic [OpW-1:0] OpSpareHi = 4'd15;
  localparam int unsigned NumPhases = 9;

  logic             clk_i;
  logic             rst_ni;
  logic             s_axis_tvalid;
  logic             s_axis_tready;
  logic [31:0]      s_axis_tdata;
  logic             m_axis_tvalid;
  logic             m_axis_tready;
  logic [31:0]      m_axis_tdata;
  logic             cfg_valid_i;
  logic             cfg_ready_o;
  logic [SizeW-1:0] cfg_data_i;

  bitmap_run_allocator dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i)
  );

  // Shadow copy of the allocator state
  logic             shadow_map [MaxBitsDefault];
  logic [SizeW-1:0] shadow_size;

  bra_rsp_t pending_rsp[$];
  int unsigned mismatch_cnt;
  bit          quiet;          // no idling on either side while set
  int unsigned hold_off_req;   // cycles for the receiver to stall

  typedef struct {
    bra_req_t req;
    bit       typed;
    bra_rsp_t rsp;
  } row_t;
  row_t directed_rows[$];

  int unsigned phase_size [NumPhases] = '{64, 1, 200, 8191, 0, 37, 256, 4096, 128};
  int unsigned phase_items[NumPhases] = '{300, 40, 300, 12, 20, 250, 300, 12, 400};

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Work out the response to one request and apply its effect to the shadow map
  function automatic bra_rsp_t allocate_and_report(bra_req_t req);
    bra_rsp_t rsp;
    int eff, s, n, run;
    bit done;
    rsp  = '0;
    eff  = (shadow_size > MaxBitsDefault) ? MaxBitsDefault : shadow_size;
    s    = int'(req.start_bit);
    n    = int'(req.run_length);
    done = 1'b0;
    if (req.op == OpClearAll) begin
      for (int i = 0; i < MaxBitsDefault; i++) shadow_map[i] = 1'b0;
    end else if (req.op <= OpSetRun && s >= eff) begin
      rsp.error = 1'b1;
    end else begin
      case (req.op)
        OpAlloc: begin
          run = 0;
          for (int i = s; i < eff && n != 0 && !done; i++) begin
            if (shadow_map[i]) begin
              run = 0;
            end else begin
              run++;
              if (run == n) begin
                rsp.found    = 1'b1;
                rsp.position = StartW'(i + 1 - n);
                for (int k = i + 1 - n; k <= i; k++) shadow_map[k] = 1'b1;
                done = 1'b1;
              end
            end
          end
        end
        OpSet, OpClear: begin
          if (s + n > eff) rsp.error = 1'b1;
          else for (int i = s; i < s + n; i++) shadow_map[i] = (req.op == OpSet);
        end
        OpFindSet, OpFindSetRun: begin
          for (int i = s; i < eff && !done; i++) begin
            if (shadow_map[i]) begin
              rsp.found    = 1'b1;
              rsp.position = StartW'(i);
              done         = 1'b1;
              if (req.op == OpFindSetRun)
                for (int k = i; k < eff && shadow_map[k]; k++) rsp.run_count++;
            end
          end
        end
        OpTest: rsp.bit_value = shadow_map[s];
        OpCountSet: for (int i = s; i < eff; i++) rsp.run_count += shadow_map[i];
        OpCountFree: for (int i = s; i < eff; i++) rsp.run_count += !shadow_map[i];
        OpFreeRun: for (int i = s; i < eff && !shadow_map[i]; i++) rsp.run_count++;
        OpSetRun: for (int i = s; i < eff && shadow_map[i]; i++) rsp.run_count++;
        default: ;
      endcase
    end
    return rsp;
  endfunction

  // Mostly allocation traffic on small sizes, with a tail of full-range noise
  function automatic bra_req_t random_request(int eff);
    bra_req_t req;
    int r;
    r = $urandom_range(99);
    if      (r < 30) req.op = OpAlloc;
    else if (r < 40) req.op = OpSet;
    else if (r < 50) req.op = OpClear;
    else if (r < 56) req.op = OpFindSet;
    else if (r < 62) req.op = OpFindSetRun;
    else if (r < 70) req.op = OpTest;
    else if (r < 76) req.op = OpCountSet;
    else if (r < 82) req.op = OpCountFree;
    else if (r < 84) req.op = OpClearAll;
    else if (r < 90) req.op = OpFreeRun;
    else if (r < 96) req.op = OpSetRun;
    else             req.op = OpW'($urandom_range(OpSpareLo, OpSpareHi));
    if ($urandom_range(99) < 85) req.start_bit = StartW'($urandom_range(0, eff + 1));
    else                         req.start_bit = StartW'($urandom_range(0, 4095));
    if ($urandom_range(99) < 8)   req.run_length = LenW'($urandom_range(0, 8191));
    else if (req.op == OpAlloc)   req.run_length = LenW'($urandom_range(1, 8));
    else                          req.run_length = LenW'($urandom_range(0, 12));
    return req;
  endfunction

  function automatic void add_row(logic [OpW-1:0] op, int s, int n, bit typed,
                                  bra_rsp_t rsp);
    row_t row;
    row.req   = '{op: op, start_bit: StartW'(s), run_length: LenW'(n)};
    row.typed = typed;
    row.rsp   = rsp;
    directed_rows.push_back(row);
  endfunction

  function automatic bra_rsp_t mk_rsp(bit f, int p, int c, bit b, bit e);
    bra_rsp_t rsp;
    rsp = '{found: f, position: StartW'(p), run_count: LenW'(c), bit_value: b, error: e};
    return rsp;
  endfunction

  // Offer one request, idling at random first; predict on acceptance
  task automatic send_request(bra_req_t req, bit typed, bra_rsp_t typed_rsp);
    bra_rsp_t predicted;
    while (!quiet && $urandom_range(99) < 35) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {3'b000, req.run_length, req.start_bit, req.op};
    do @(posedge clk_i); while (!s_axis_tready);
    predicted = allocate_and_report(req);
    pending_rsp.push_back(typed ? typed_rsp : predicted);
  endtask

  // Resize the bitmap once the engine has drained
  task automatic write_size(int unsigned sz);
    s_axis_tvalid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= SizeW'(sz);
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    shadow_size = SizeW'(sz);
  endtask

  // Response side: check each response and stall at random
  initial begin
    bra_rsp_t got, want;
    int unsigned hold_left;
    hold_left = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        got = '{found: m_axis_tdata[0], position: m_axis_tdata[12:1],
                run_count: m_axis_tdata[25:13], bit_value: m_axis_tdata[26],
                error: m_axis_tdata[27]};
        if (pending_rsp.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) $display("unexpected response %p", got);
        end else begin
          want = pending_rsp.pop_front();
          if (got.found !== want.found || got.position !== want.position ||
              got.run_count !== want.run_count || got.bit_value !== want.bit_value ||
              got.error !== want.error) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10) $display("response mismatch: expected %p got %p", want, got);
          end
        end
      end
      if (hold_off_req != 0) begin
        hold_left    = hold_off_req;
        hold_off_req = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= quiet || ($urandom_range(99) >= 35);
      end
    end
  end

  // Request side
  initial begin
    bra_rsp_t none;
    int eff;
    none          = '0;
    mismatch_cnt  = 0;
    quiet         = 1'b0;
    hold_off_req  = 0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = '0;
    shadow_size   = SizeW'(MaxBitsDefault);
    for (int i = 0; i < MaxBitsDefault; i++) shadow_map[i] = 1'b0;
    rst_ni = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part on the full bitmap straight after reset
    add_row(OpTest,       0,    0,    1, none);
    add_row(OpFindSet,    0,    0,    1, none);
    add_row(OpCountFree,  0,    0,    1, mk_rsp(0, 0, 4096, 0, 0));
    add_row(OpCountSet,   4095, 0,    1, none);
    add_row(OpSet,        4095, 2,    1, mk_rsp(0, 0, 0, 0, 1));
    add_row(OpClear,      0,    4097, 1, mk_rsp(0, 0, 0, 0, 1));
    add_row(OpAlloc,      0,    0,    1, none);
    add_row(OpAlloc,      0,    8191, 1, none);
    add_row(OpAlloc,      0,    4,    1, mk_rsp(1, 0, 0, 0, 0));
    add_row(OpAlloc,      0,    3,    1, mk_rsp(1, 4, 0, 0, 0));
    add_row(OpSet,        4090, 6,    1, none);
    add_row(OpFindSetRun, 100,  0,    0, none);
    add_row(OpTest,       4095, 0,    0, none);
    add_row(OpSetRun,     4093, 0,    0, none);
    add_row(OpFreeRun,    7,    0,    0, none);
    add_row(OpClear,      2,    3,    0, none);
    add_row(OpAlloc,      0,    2,    0, none);
    add_row(OpCountSet,   0,    0,    0, none);
    add_row(OpSet,        0,    0,    0, none);
    add_row(OpSpareLo,    5,    1,    1, none);
    add_row(OpSpareHi,    4095, 8191, 1, none);
    add_row(OpFindSetRun, 0,    0,    0, none);
    add_row(OpClearAll,   4095, 8191, 1, none);
    add_row(OpFindSetRun, 0,    0,    0, none);
    add_row(OpCountFree,  4095, 0,    0, none);
    foreach (directed_rows[i])
      send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].rsp);

    // Random phases over a range of sizes; hold back until drained between them
    for (int p = 0; p < NumPhases; p++) begin
      write_size(phase_size[p]);
      eff   = (phase_size[p] > MaxBitsDefault) ? MaxBitsDefault : phase_size[p];
      quiet = (p == 5);
      if (p == 2) hold_off_req = 400;
      for (int k = 0; k < phase_items[p]; k++)
        send_request(random_request(eff), 1'b0, none);
    end
    s_axis_tvalid <= 1'b0;
    quiet = 1'b0;

    while (pending_rsp.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (mismatch_cnt == 0 && pending_rsp.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #40_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
